>>> rtl/netu_pkg.sv
`default_nettype none
package netu_pkg;
  localparam int MAX_NAME_LEN = 10;
  localparam int TABLE_ENTRIES = 126;
  localparam int LEN_W = 4;
  localparam int NAME_W = 8 * MAX_NAME_LEN;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_AMP = 8'h26;

  // kinds of work handed from front to back
  localparam logic [1:0] OP_BYTE = 2'd0;  // emit one byte
  localparam logic [1:0] OP_FLUSH = 2'd1; // emit '&' + name, then optional tail byte
  localparam logic [1:0] OP_UTF8 = 2'd2;  // emit code point

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] tail;        // byte following a literal flush, or the single byte
    logic tail_en;
    logic [LEN_W-1:0] len;
    logic [NAME_W-1:0] name;
    logic [15:0] cp;
  } job_t;

  typedef struct packed {
    logic [8*MAX_NAME_LEN-1:0] nm;
    logic [LEN_W-1:0] len;
    logic [15:0] cp;
  } sym_t;

  function automatic sym_t mk(input string s, input logic [15:0] cp);
    sym_t r;
    r.nm = '0;
    r.len = LEN_W'(s.len());
    r.cp = cp;
    for (int i = 0; i < MAX_NAME_LEN; i++)
      if (i < s.len()) r.nm[8*i +: 8] = s[i];
    return r;
  endfunction

  function automatic sym_t sym_rom(input logic [6:0] idx);
    sym_t r;
    unique case (idx)
      7'd0: r = mk("Alpha",16'h391); 7'd1: r = mk("Beta",16'h392);
      7'd2: r = mk("Gamma",16'h393); 7'd3: r = mk("Delta",16'h394);
      7'd4: r = mk("Epsilon",16'h395); 7'd5: r = mk("Zeta",16'h396);
      7'd6: r = mk("Eta",16'h397); 7'd7: r = mk("Theta",16'h398);
      7'd8: r = mk("Iota",16'h399); 7'd9: r = mk("Kappa",16'h39A);
      7'd10: r = mk("Lambda",16'h39B); 7'd11: r = mk("Mu",16'h39C);
      7'd12: r = mk("Nu",16'h39D); 7'd13: r = mk("Xi",16'h39E);
      7'd14: r = mk("Omicron",16'h39F); 7'd15: r = mk("Pi",16'h3A0);
      7'd16: r = mk("Rho",16'h3A1); 7'd17: r = mk("Sigma",16'h3A3);
      7'd18: r = mk("Tau",16'h3A4); 7'd19: r = mk("Upsilon",16'h3A5);
      7'd20: r = mk("Phi",16'h3A6); 7'd21: r = mk("Chi",16'h3A7);
      7'd22: r = mk("Psi",16'h3A8); 7'd23: r = mk("Omega",16'h3A9);
      7'd24: r = mk("alpha",16'h3B1); 7'd25: r = mk("beta",16'h3B2);
      7'd26: r = mk("gamma",16'h3B3); 7'd27: r = mk("delta",16'h3B4);
      7'd28: r = mk("epsilon",16'h3B5); 7'd29: r = mk("varepsilon",16'h3F5);
      7'd30: r = mk("zeta",16'h3B6); 7'd31: r = mk("eta",16'h3B7);
      7'd32: r = mk("theta",16'h3B8); 7'd33: r = mk("thetasym",16'h3D1);
      7'd34: r = mk("iota",16'h3B9); 7'd35: r = mk("kappa",16'h3BA);
      7'd36: r = mk("varkappa",16'h3F0); 7'd37: r = mk("lambda",16'h3BB);
      7'd38: r = mk("mu",16'h3BC); 7'd39: r = mk("nu",16'h3BD);
      7'd40: r = mk("xi",16'h3BE); 7'd41: r = mk("omicron",16'h3BF);
      7'd42: r = mk("pi",16'h3C0); 7'd43: r = mk("rho",16'h3C1);
      7'd44: r = mk("varrho",16'h3F1); 7'd45: r = mk("sigma",16'h3C3);
      7'd46: r = mk("sigmaf",16'h3C2); 7'd47: r = mk("tau",16'h3C4);
      7'd48: r = mk("upsilon",16'h3C5); 7'd49: r = mk("phi",16'h3C6);
      7'd50: r = mk("chi",16'h3C7); 7'd51: r = mk("psi",16'h3C8);
      7'd52: r = mk("omega",16'h3C9); 7'd53: r = mk("alefsym",16'h2135);
      7'd54: r = mk("and",16'h2227); 7'd55: r = mk("ang",16'h2220);
      7'd56: r = mk("asymp",16'h2248); 7'd57: r = mk("cap",16'h2229);
      7'd58: r = mk("cong",16'h2245); 7'd59: r = mk("cup",16'h222A);
      7'd60: r = mk("deg",16'hB0); 7'd61: r = mk("divide",16'hF7);
      7'd62: r = mk("empty",16'h2205); 7'd63: r = mk("equiv",16'h2261);
      7'd64: r = mk("exist",16'h2203); 7'd65: r = mk("fnof",16'h192);
      7'd66: r = mk("forall",16'h2200); 7'd67: r = mk("ge",16'h2265);
      7'd68: r = mk("image",16'h2111); 7'd69: r = mk("infin",16'h221E);
      7'd70: r = mk("int",16'h222B); 7'd71: r = mk("isin",16'h2208);
      7'd72: r = mk("lArr",16'h21D0); 7'd73: r = mk("lang",16'h2329);
      7'd74: r = mk("larr",16'h2190); 7'd75: r = mk("le",16'h2264);
      7'd76: r = mk("lfloor",16'h230A); 7'd77: r = mk("micro",16'hB5);
      7'd78: r = mk("middot",16'hB7); 7'd79: r = mk("minus",16'h2212);
      7'd80: r = mk("nabla",16'h2207); 7'd81: r = mk("ne",16'h2260);
      7'd82: r = mk("ni",16'h220B); 7'd83: r = mk("not",16'hAC);
      7'd84: r = mk("notin",16'h2209); 7'd85: r = mk("nsub",16'h2284);
      7'd86: r = mk("oplus",16'h2295); 7'd87: r = mk("or",16'h2228);
      7'd88: r = mk("otimes",16'h2297); 7'd89: r = mk("part",16'h2202);
      7'd90: r = mk("permil",16'h2030); 7'd91: r = mk("perp",16'h22A5);
      7'd92: r = mk("piv",16'h3D6); 7'd93: r = mk("plusmn",16'hB1);
      7'd94: r = mk("prod",16'h220F); 7'd95: r = mk("prop",16'h221D);
      7'd96: r = mk("rArr",16'h21D2); 7'd97: r = mk("radic",16'h221A);
      7'd98: r = mk("rang",16'h232A); 7'd99: r = mk("rarr",16'h2192);
      7'd100: r = mk("rceil",16'h2309); 7'd101: r = mk("real",16'h211C);
      7'd102: r = mk("rfloor",16'h230B); 7'd103: r = mk("sdot",16'h22C5);
      7'd104: r = mk("sim",16'h223C); 7'd105: r = mk("sub",16'h2282);
      7'd106: r = mk("sube",16'h2286); 7'd107: r = mk("sum",16'h2211);
      7'd108: r = mk("sup",16'h2283); 7'd109: r = mk("there4",16'h2234);
      7'd110: r = mk("times",16'hD7); 7'd111: r = mk("weierp",16'h2118);
      7'd112: r = mk("bull",16'h2022); 7'd113: r = mk("cent",16'hA2);
      7'd114: r = mk("circ",16'h2C6); 7'd115: r = mk("copy",16'hA9);
      7'd116: r = mk("curren",16'hA4); 7'd117: r = mk("Dagger",16'h2021);
      7'd118: r = mk("dagger",16'h2020); 7'd119: r = mk("euro",16'h20AC);
      7'd120: r = mk("hellip",16'h2026); 7'd121: r = mk("pound",16'hA3);
      7'd122: r = mk("reg",16'hAE); 7'd123: r = mk("sect",16'hA7);
      7'd124: r = mk("trade",16'h2122); 7'd125: r = mk("yen",16'hA5);
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/named_entity_to_utf8_decoder.sv
`default_nettype none
// Text byte stream in, UTF-8 out, with named entities "&name;" replaced from a
// 126-entry symbol ROM. Input takes one byte per cycle while in_full is low; a
// byte that emits one result is registered in the job queue before it reaches
// the output. Flushes and code points emit several bytes from the emitter, one
// per cycle while out_pop is high; a two-entry job queue between classifier
// and emitter absorbs that, and in_full rises only while the queue is full.
module named_entity_to_utf8_decoder import netu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_end_of_text,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_out_byte,
  output logic            out_last_of_run
);
  logic fv, fr, qv, qt;
  job_t fj, qj;

  netu_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_text_byte, .in_end_of_text,
    .job_valid(fv), .job(fj), .job_ready(fr)
  );
  netu_queue u_queue (
    .clk, .rst_n, .wr_valid(fv), .wr_job(fj), .wr_ready(fr),
    .rd_valid(qv), .rd_job(qj), .rd_take(qt)
  );
  netu_back u_back (
    .clk, .rst_n, .job_valid(qv), .job(qj), .job_take(qt),
    .out_empty, .out_pop, .out_out_byte, .out_last_of_run
  );
endmodule
`default_nettype wire

>>> rtl/netu_front.sv
`default_nettype none
module netu_front import netu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_end_of_text,
  output logic            job_valid,
  output job_t            job,
  input  wire logic       job_ready
);
  logic in_entity_r, in_entity_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [NAME_W-1:0] name_r, name_nxt;
  logic [15:0] cp;
  logic hit;
  logic take;

  // match the buffered name against every ROM entry in parallel
  always_comb begin
    sym_t s;
    hit = 1'b0;
    cp = '0;
    for (int e = 0; e < TABLE_ENTRIES; e++) begin
      s = sym_rom(7'(e));
      if (s.len == len_r && s.nm == name_r) begin
        hit = 1'b1;
        cp = s.cp;
      end
    end
  end

  assign in_full = !job_ready;
  assign take = in_push && job_ready;

  // classify the item and advance the entity buffer
  always_comb begin
    in_entity_nxt = in_entity_r;
    len_nxt = len_r;
    name_nxt = name_r;
    job_valid = 1'b0;
    job = '0;
    job.len = len_r;
    job.name = name_r;
    job.cp = cp;
    job.tail = in_text_byte;
    if (take) begin
      priority if (in_end_of_text) begin
        if (in_entity_r) begin
          job_valid = 1'b1; job.op = OP_FLUSH;
        end
        in_entity_nxt = 1'b0; len_nxt = '0;
      end else if (in_text_byte == CH_AMP) begin
        if (in_entity_r) begin
          job_valid = 1'b1; job.op = OP_FLUSH;
        end
        // start a fresh name; bytes past the length must read as zero for the match
        in_entity_nxt = 1'b1; len_nxt = '0; name_nxt = '0;
      end else if (!in_entity_r) begin
        job_valid = 1'b1; job.op = OP_BYTE;
      end else if (in_text_byte == CH_SEMI) begin
        job_valid = 1'b1;
        if (hit) job.op = OP_UTF8;
        else begin
          job.op = OP_FLUSH; job.tail_en = 1'b1;
        end
        in_entity_nxt = 1'b0; len_nxt = '0;
      end else if (len_r < LEN_W'(MAX_NAME_LEN)) begin
        name_nxt[8*len_r +: 8] = in_text_byte;
        len_nxt = len_r + 1'b1;
      end else begin
        job_valid = 1'b1; job.op = OP_FLUSH; job.tail_en = 1'b1;
        in_entity_nxt = 1'b0; len_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_entity_r <= 1'b0;
      len_r <= '0;
      name_r <= '0;
    end else begin
      in_entity_r <= in_entity_nxt;
      len_r <= len_nxt;
      name_r <= name_nxt;
    end
  end
endmodule
`default_nettype wire

>>> rtl/netu_queue.sv
`default_nettype none
module netu_queue import netu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  input  wire job_t wr_job,
  output logic      wr_ready,
  output logic      rd_valid,
  output job_t      rd_job,
  input  wire logic rd_take
);
  job_t q_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  logic wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_job = q_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_take && rd_valid;

  // two-entry queue between classifier and emitter
  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= wr_job;
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

>>> rtl/netu_back.sv
`default_nettype none
module netu_back import netu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic job_valid,
  input  wire job_t job,
  output logic      job_take,
  output logic       out_empty,
  input  wire logic  out_pop,
  output logic [7:0] out_out_byte,
  output logic       out_last_of_run
);
  // step 0 is '&', steps 1..len the name, step len+1 the tail
  logic [LEN_W:0] step_r;
  logic [7:0] b;
  logic last;
  logic [15:0] cp;
  logic three;

  assign cp = job.cp;
  assign three = cp >= 16'h800;

  always_comb begin
    b = job.tail;
    last = 1'b1;
    unique case (job.op)
      OP_FLUSH: begin
        if (step_r == '0) b = CH_AMP;
        else if (step_r <= {1'b0, job.len}) b = job.name[8*step_r[LEN_W-1:0]-8 +: 8];
        last = job.tail_en ? (step_r == {1'b0, job.len} + 1'b1)
                           : (step_r == {1'b0, job.len});
      end
      OP_UTF8: begin
        if (three) begin
          unique case (step_r[1:0])
            2'd0: b = {4'hE, cp[15:12]};
            2'd1: b = {2'b10, cp[11:6]};
            default: b = {2'b10, cp[5:0]};
          endcase
          last = step_r[1:0] == 2'd2;
        end else begin
          b = step_r[0] ? {2'b10, cp[5:0]} : {3'b110, cp[10:6]};
          last = step_r[0];
        end
      end
      default: begin
        b = job.tail; last = 1'b1;
      end
    endcase
  end

  assign out_empty = !job_valid;
  assign out_out_byte = b;
  assign out_last_of_run = last;
  assign job_take = job_valid && out_pop && last;

  // advance through the bytes of the current job
  always_ff @(posedge clk) begin
    if (!rst_n) step_r <= '0;
    else if (job_valid && out_pop) step_r <= last ? '0 : step_r + 1'b1;
  end
endmodule
`default_nettype wire
